>>> hdl/ile_pkg.sv
// shared types and constants for the indexed list engine
package ile_pkg;

  localparam int ILE_CAPACITY   = 64;
  localparam int ILE_DATA_WIDTH = 32;
  localparam int POS_W          = 7;
  localparam int VAL_W          = 32;
  localparam int CNT_W          = 7;

  typedef enum logic [1:0] {
    REQ_PEEK    = 2'd0,
    REQ_REPLACE = 2'd1,
    REQ_INSERT  = 2'd2,
    REQ_REMOVE  = 2'd3
  } ile_req_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_REMOVE
  } ile_cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ
  } ile_state_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value_in;
  } ile_in_t;

  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] value_out;
    logic [CNT_W-1:0] count;
  } ile_out_t;

endpackage

>>> hdl/indexed_list_engine_unit.sv
// top level of the indexed list engine: request decode, cell row and result register
//
// The list lives in a row of CAPACITY cells; an insert shifts every cell at or above
// the position up by one and a remove shifts every cell above it down by one, in the
// same edge that takes the item. Replace, insert and remove (accepted or rejected),
// and a peek of an empty list, are answered directly in the result register, so one
// such item per cycle is accepted while the result register drains. A peek of a
// non-empty list folds the position by the element count in a bit-serial remainder
// unit, one position bit per cycle, and then reads the selected cell into the result
// register; no new item is accepted meanwhile. Entries are not reset and no clearing
// pass runs after reset; only positions below the count are ever read.
module indexed_list_engine_unit import ile_pkg::*; #(
  parameter int CAPACITY   = ILE_CAPACITY,
  parameter int DATA_WIDTH = ILE_DATA_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ile_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ile_out_t out_data
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL = CW'(CAPACITY);

  ile_state_t   state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic         out_valid_r, out_valid_nxt;
  ile_out_t     out_r, out_nxt;

  ile_cell_op_t          cell_op;
  logic [IW-1:0]         pos_idx;
  logic [IW-1:0]         rd_idx;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_word;

  logic          accept;
  logic          mod_start;
  logic          mod_done;
  logic [CW-1:0] mod_rem;
  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic          in_range;
  logic          ins_ok;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign pos_ext  = CMPW'(in_data.position);
  assign cnt_ext  = CMPW'(count_r);
  assign in_range = pos_ext < cnt_ext;
  assign ins_ok   = (count_r != FULL) && (pos_ext <= cnt_ext);
  assign pos_idx  = IW'(in_data.position);
  assign wr_data  = DATA_WIDTH'(in_data.value_in);
  assign rd_idx   = IW'(mod_rem);

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    cell_op       = CELL_HOLD;
    mod_start     = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_nxt.value_out = '0;
          case (ile_req_t'(in_data.req_type))
            REQ_PEEK: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt.ok    = 1'b0;
                out_nxt.count = CNT_W'(count_r);
              end else begin
                mod_start = 1'b1;
                state_nxt = ST_MOD;
              end
            end
            REQ_REPLACE: begin
              if (in_range) begin
                cell_op = CELL_WRITE;
              end
              out_valid_nxt = 1'b1;
              out_nxt.ok    = in_range;
              out_nxt.count = CNT_W'(count_r);
            end
            REQ_INSERT: begin
              if (ins_ok) begin
                cell_op   = CELL_INSERT;
                count_nxt = count_r + 1'b1;
              end
              out_valid_nxt = 1'b1;
              out_nxt.ok    = ins_ok;
              out_nxt.count = CNT_W'(count_nxt);
            end
            REQ_REMOVE: begin
              if (in_range) begin
                cell_op   = CELL_REMOVE;
                count_nxt = count_r - 1'b1;
              end
              out_valid_nxt = 1'b1;
              out_nxt.ok    = in_range;
              out_nxt.count = CNT_W'(count_nxt);
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt.ok    = 1'b0;
              out_nxt.count = CNT_W'(count_r);
            end
          endcase
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        out_valid_nxt     = 1'b1;
        out_nxt.ok        = 1'b1;
        out_nxt.value_out = VAL_W'(rd_word);
        out_nxt.count     = CNT_W'(count_r);
        state_nxt         = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  ile_mod_unit #(
    .CW(CW)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .dividend(in_data.position),
    .divisor (count_r),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = cell_data[g+1];
    end

    ile_cell #(
      .INDEX     (g),
      .DATA_WIDTH(DATA_WIDTH),
      .IW        (IW)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .pos       (pos_idx),
      .wr_data   (wr_data),
      .left_data (left_w),
      .right_data(right_w),
      .rd_idx    (rd_idx),
      .data      (cell_data[g]),
      .rd_data   (cell_rd[g])
    );
  end

endmodule

>>> hdl/ile_cell.sv
// one list slot: holds an element and shifts it to or from its neighbours
module ile_cell import ile_pkg::*; #(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = ILE_DATA_WIDTH,
  parameter int IW         = 6
) (
  input  logic                  clk,
  input  ile_cell_op_t          op,
  input  logic [IW-1:0]         pos,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [IW-1:0]         rd_idx,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] rd_data
);

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (op)
      CELL_WRITE: begin
        if (MY_IDX == pos) begin
          data_nxt = wr_data;
        end
      end
      CELL_INSERT: begin
        if (MY_IDX > pos) begin
          data_nxt = left_data;
        end else if (MY_IDX == pos) begin
          data_nxt = wr_data;
        end
      end
      CELL_REMOVE: begin
        if (MY_IDX >= pos) begin
          data_nxt = right_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (rd_idx == MY_IDX) ? data_r : '0;

endmodule

>>> hdl/ile_mod_unit.sv
// bit-serial remainder of a position by the element count
module ile_mod_unit import ile_pkg::*; #(
  parameter int CW = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [POS_W-1:0] dividend,
  input  logic [CW-1:0]    divisor,
  output logic             done,
  output logic [CW-1:0]    rem
);

  localparam int SW = $clog2(POS_W);
  localparam logic [SW-1:0] LAST_STEP = SW'(POS_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [SW-1:0]    step_r, step_nxt;
  logic [POS_W-1:0] q_r, q_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic [CW:0]      trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, q_r[POS_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_nxt  = trial[CW-1:0];
      q_nxt    = {q_r[POS_W-2:0], 1'b0};
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> dv/tb_indexed_list_engine_unit.sv
// self-checking testbench for the indexed list engine: directed and random requests
module tb_indexed_list_engine_unit;
  import ile_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS    = 620;
  localparam int WIND_DOWN      = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 30;
  localparam logic [VAL_W-1:0] VALUE_MASK = (ILE_DATA_WIDTH >= VAL_W) ? {VAL_W{1'b1}} :
                                            VAL_W'((64'd1 << ILE_DATA_WIDTH) - 1);

  typedef struct {
    ile_in_t req;
    bit      settle;
  } pending_req_t;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  ile_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ile_out_t out_data;

  pending_req_t request_q[$];
  ile_out_t     awaited_results[$];
  logic [VAL_W-1:0] shadow_words [ILE_CAPACITY];
  int shadow_len     = 0;
  int gen_len        = 0;
  int mismatches     = 0;
  int cycle_count    = 0;
  int quiet_cycles   = 0;
  int send_gap       = 0;
  int recv_gap       = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;

  indexed_list_engine_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  function automatic ile_out_t apply_request(input ile_in_t r);
    ile_out_t res;
    int p;
    int i;
    logic [VAL_W-1:0] v;
    res = '0;
    p = r.position;
    v = r.value_in & VALUE_MASK;
    case (ile_req_t'(r.req_type))
      REQ_PEEK: begin
        if (shadow_len != 0) begin
          res.ok = 1'b1;
          res.value_out = shadow_words[p % shadow_len];
        end
      end
      REQ_REPLACE: begin
        if (p < shadow_len) begin
          shadow_words[p] = v;
          res.ok = 1'b1;
        end
      end
      REQ_INSERT: begin
        if (shadow_len < ILE_CAPACITY && p <= shadow_len) begin
          for (i = shadow_len; i > p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p] = v;
          shadow_len++;
          res.ok = 1'b1;
        end
      end
      default: begin
        if (p < shadow_len) begin
          for (i = p; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
          res.ok = 1'b1;
        end
      end
    endcase
    res.count = CNT_W'(shadow_len);
    return res;
  endfunction

  task automatic queue_request(input ile_req_t kind, input int pos,
                               input logic [VAL_W-1:0] val, input bit settle);
    pending_req_t item;
    item.req.req_type = kind;
    item.req.position = POS_W'(pos);
    item.req.value_in = val;
    item.settle = settle;
    request_q.push_back(item);
    case (kind)
      REQ_INSERT: if (gen_len < ILE_CAPACITY && pos <= gen_len) gen_len++;
      REQ_REMOVE: if (pos < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  task automatic queue_random(input int ins_pct, input int rem_pct, input bit settle);
    int roll;
    int pos;
    ile_req_t kind;
    logic [VAL_W-1:0] val;
    roll = $urandom_range(99, 0);
    if (roll < ins_pct) kind = REQ_INSERT;
    else if (roll < ins_pct + rem_pct) kind = REQ_REMOVE;
    else if ($urandom_range(1, 0) == 0) kind = REQ_PEEK;
    else kind = REQ_REPLACE;
    // noise positions, and peeks past the end that wrap round the list
    if ($urandom_range(9, 0) == 0) pos = $urandom_range(127, 0);
    else if (kind == REQ_INSERT) pos = $urandom_range(gen_len, 0);
    else if (kind == REQ_PEEK && $urandom_range(3, 0) == 0) pos = $urandom_range(127, 0);
    else pos = (gen_len == 0) ? 0 : $urandom_range(gen_len - 1, 0);
    case ($urandom_range(7, 0))
      0: val = '0;
      1: val = '1;
      default: val = $urandom;
    endcase
    queue_request(kind, pos, val, settle);
  endtask

  initial begin
    int guard;
    bit settle_next;

    // directed: empty list, bounds, wrap-round peeks, front, middle and end
    queue_request(REQ_PEEK,    0,   '0, 1'b0);
    queue_request(REQ_REPLACE, 0,   '1, 1'b0);
    queue_request(REQ_REMOVE,  0,   '0, 1'b0);
    queue_request(REQ_INSERT,  1,   '1, 1'b0);
    queue_request(REQ_INSERT,  0,   32'hFFFF_FFFF, 1'b0);
    queue_request(REQ_INSERT,  1,   32'h0000_0000, 1'b0);
    queue_request(REQ_INSERT,  1,   32'hA5A5_A5A5, 1'b0);
    queue_request(REQ_INSERT,  0,   32'h0000_0001, 1'b0);
    queue_request(REQ_PEEK,    0,   '0, 1'b0);
    queue_request(REQ_PEEK,    3,   '0, 1'b0);
    queue_request(REQ_PEEK,    127, '1, 1'b0);
    queue_request(REQ_PEEK,    64,  '0, 1'b0);
    queue_request(REQ_REPLACE, 3,   32'h8000_0000, 1'b0);
    queue_request(REQ_REPLACE, 4,   32'h5A5A_5A5A, 1'b0);
    queue_request(REQ_REMOVE,  4,   '0, 1'b0);
    queue_request(REQ_REMOVE,  127, '0, 1'b0);
    queue_request(REQ_INSERT,  127, '1, 1'b0);
    queue_request(REQ_PEEK,    5,   '0, 1'b0);
    queue_request(REQ_REMOVE,  1,   '0, 1'b0);
    queue_request(REQ_REMOVE,  2,   '0, 1'b0);
    queue_request(REQ_REMOVE,  0,   '0, 1'b0);
    queue_request(REQ_PEEK,    1,   '0, 1'b0);
    queue_request(REQ_PEEK,    0,   '0, 1'b0);

    settle_next = 1'b1;
    while (request_q.size() < TOTAL_ITEMS) begin
      case ($urandom_range(2, 0))
        0: begin
          // fill to capacity, then push against the full list
          guard = 0;
          while (gen_len < ILE_CAPACITY && guard < 300) begin
            queue_random(80, 5, settle_next);
            settle_next = 1'b0;
            guard++;
          end
          repeat (4) queue_random(70, 0, 1'b0);
        end
        1: begin
          guard = 0;
          while (gen_len > 0 && guard < 300) begin
            queue_random(5, 80, settle_next);
            settle_next = 1'b0;
            guard++;
          end
          repeat (3) queue_random(30, 30, 1'b0);
        end
        default: begin
          repeat (40) begin
            queue_random(35, 30, settle_next);
            settle_next = 1'b0;
          end
        end
      endcase
      settle_next = ($urandom_range(2, 0) == 0);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_request(in_data));
      end
      if (!in_valid || in_ready) begin
        if (cycle_count % 200 == 0) send_idle_pct = 15 * $urandom_range(2, 0);
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0 &&
                     !(request_q[0].settle && awaited_results.size() != 0)) begin
          in_valid <= 1'b1;
          in_data  <= request_q[0].req;
          request_q.delete(0);
          if (request_q.size() >= WIND_DOWN && $urandom_range(99, 0) < send_idle_pct)
            send_gap = $urandom_range(3, 1);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ile_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("result with nothing outstanding");
        end else begin
          want = awaited_results.pop_front();
          if (out_data.ok !== want.ok)
            flag_mismatch($sformatf("ok %0b, want %0b", out_data.ok, want.ok));
          if (out_data.value_out !== want.value_out)
            flag_mismatch($sformatf("value_out %h, want %h",
                                    out_data.value_out, want.value_out));
          if (out_data.count !== want.count)
            flag_mismatch($sformatf("count %0d, want %0d", out_data.count, want.count));
        end
      end
      if (cycle_count % 170 == 0) recv_idle_pct = 15 * $urandom_range(2, 0);
      if (recv_gap != 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (request_q.size() >= WIND_DOWN && $urandom_range(99, 0) < recv_idle_pct)
          recv_gap = $urandom_range(3, 1);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
